FILE: rtl/core/bdq_pkg.sv
// Shared types and codes for the byte deque unit.
// No dependencies; imported by byte_deque_unit.
package bdq_pkg;

    // Operation codes carried in the request kind field
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [2:0] KIND_POP_BACK   = 3'd2;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [2:0] KIND_DUMP_FWD   = 3'd4;
    localparam logic [2:0] KIND_DUMP_REV   = 3'd5;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
    } t_req;

    typedef struct packed {
        logic [7:0] item_value;
        logic       is_item;
        logic [1:0] status;
        logic       last;
    } t_rsp;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage

FILE: rtl/core/bdq_store.sv
// Ring element store: one write port, one registered read port.
// Read address is the front index plus an offset, wrapped at DEPTH.
// Depends on nothing outside this file.
module bdq_store #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]               i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_front,
    input  logic [$clog2(DEPTH)-1:0] i_rd_off,
    output logic [7:0]               o_rd_data
);
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW:0]   rd_sum;
    logic [AW-1:0] rd_addr;

    // Both terms are below DEPTH, so one subtract wraps the sum
    always_comb begin
        rd_sum = {1'b0, i_front} + {1'b0, i_rd_off};
        if (rd_sum >= DEPTH_W) begin
            rd_sum = rd_sum - DEPTH_W;
        end
        rd_addr = rd_sum[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/byte_deque_unit.sv
// Top level of the byte deque: request decode, ring pointers, dump sequencer.
// Depends on bdq_pkg and bdq_store.
//
//  Channel   Handshake            Payload   Notes
//  request   start && !busy       i_req     kind, value
//  result    o_valid (1 cycle)    o_rsp     item_value, is_item, status, last
//
// Push, pop, empty-dump and one-element dump requests leave busy low; the result
// follows in the cycle after acceptance and busy stays low, so one request per cycle.
// A dump of two or more stored elements holds busy until its last store read is issued,
// one store read per cycle on the single read port; each item appears the cycle after its read.
// Reset (synchronous, active low) empties the deque; store contents are kept.
// The receiver cannot stall: every result is shown for exactly one cycle.
module byte_deque_unit
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_rsp o_rsp
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_rev, n_rev;
    logic          r_out_vld, n_out_vld;
    logic          r_out_item, n_out_item;
    logic [1:0]    r_out_status, n_out_status;
    logic          r_out_last, n_out_last;

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_off;
    logic [7:0]    rd_data;
    logic [AW:0]   back_sum;
    logic [AW-1:0] back_pos;
    logic [AW-1:0] next_front;
    logic [CW-1:0] count_m1;
    logic          dump_done;

    assign accept   = start && !busy;
    assign count_m1 = r_count - CW'(1);
    assign dump_done = ({{(CW-AW){1'b0}}, r_idx} == count_m1);

    // Slot just past the back element
    always_comb begin
        back_sum = {1'b0, r_front} + {1'b0, r_count[AW-1:0]};
        if (back_sum >= DEPTH_W) begin
            back_sum = back_sum - DEPTH_W;
        end
        back_pos = back_sum[AW-1:0];
    end

    always_comb begin
        next_front = (r_front == LAST_POS) ? '0 : r_front + AW'(1);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_req.kind == KIND_DUMP_FWD || i_req.kind == KIND_DUMP_REV)
                        && r_count > CW'(1)) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (dump_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_DUMP: busy = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    // Datapath
    always_comb begin
        n_front      = r_front;
        n_count      = r_count;
        n_idx        = r_idx;
        n_rev        = r_rev;
        wr_en        = 1'b0;
        wr_addr      = back_pos;
        rd_en        = 1'b0;
        rd_off       = '0;
        n_out_vld    = 1'b0;
        n_out_item   = 1'b0;
        n_out_status = STATUS_OK;
        n_out_last   = 1'b1;

        if (r_state == ST_DUMP) begin
            rd_en      = 1'b1;
            rd_off     = r_rev ? (count_m1[AW-1:0] - r_idx) : r_idx;
            n_out_vld  = 1'b1;
            n_out_item = 1'b1;
            n_out_last = dump_done;
            n_idx      = r_idx + AW'(1);
        end else if (accept) begin
            case (i_req.kind)
                KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                    n_out_vld = 1'b1;
                    if (r_count == FULL_CNT) begin
                        n_out_status = STATUS_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                        if (i_req.kind == KIND_PUSH_FRONT) begin
                            // Step front back by one and store there
                            n_front = (r_front == '0) ? LAST_POS : r_front - AW'(1);
                            wr_addr = n_front;
                        end
                    end
                end
                KIND_POP_BACK, KIND_POP_FRONT: begin
                    n_out_vld = 1'b1;
                    if (r_count == '0) begin
                        n_out_status = STATUS_EMPTY;
                    end else begin
                        n_count = count_m1;
                        if (i_req.kind == KIND_POP_FRONT) begin
                            n_front = next_front;
                        end
                    end
                end
                KIND_DUMP_FWD, KIND_DUMP_REV: begin
                    n_out_vld = 1'b1;
                    if (r_count == '0) begin
                        n_out_status = STATUS_EMPTY;
                    end else begin
                        n_rev      = (i_req.kind == KIND_DUMP_REV);
                        rd_en      = 1'b1;
                        rd_off     = n_rev ? count_m1[AW-1:0] : '0;
                        n_out_item = 1'b1;
                        n_out_last = (r_count == CW'(1));
                        n_idx      = AW'(1);
                    end
                end
                default: begin
                    // Undefined kind: drop silently
                    n_out_vld = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_rev     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_rev     <= n_rev;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item   <= n_out_item;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    bdq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_req.value),
        .i_rd_en   (rd_en),
        .i_front   (r_front),
        .i_rd_off  (rd_off),
        .o_rd_data (rd_data)
    );

    always_comb begin
        o_valid          = r_out_vld;
        o_rsp.item_value = r_out_item ? rd_data : 8'd0;
        o_rsp.is_item    = r_out_item;
        o_rsp.status     = r_out_status;
        o_rsp.last       = r_out_last;
    end

endmodule
